// ===== src/brf_pkg.sv =====
package brf_pkg;

    localparam int DEPTH   = 256;
    localparam int MAX_LEN = 64;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int LEN_W  = 7;
    localparam int DATA_W = 8;
    localparam int TYPE_W = 2;
    localparam int ST_W   = 3;
    localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    localparam int S_TDATA_W = ((LEN_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + LEN_W + 7) / 8) * 8;

    typedef enum logic [TYPE_W-1:0] {
        REQ_PUT_START = 2'd0,
        REQ_PUT_BYTE  = 2'd1,
        REQ_GET       = 2'd2,
        REQ_CLEAR     = 2'd3
    } t_req;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_NO_SPACE = 3'd1,
        ST_CAPACITY = 3'd2,
        ST_NO_DATA  = 3'd3,
        ST_SEQUENCE = 3'd4
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic exec;
        logic step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic start_stream;
        logic last_byte;
    } t_sts;

endpackage

// ===== src/brf_ctrl.sv =====
module brf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output brf_pkg::t_cmd o_cmd,
    input  brf_pkg::t_sts i_sts
);
    import brf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_STREAM
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd.load_req = 1'b0;
        o_cmd.exec     = 1'b0;
        o_cmd.step     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (r_ready && i_s_tvalid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_sts.start_stream ? S_STREAM : S_IDLE;
                end
            end
            S_STREAM: begin
                if (i_sts.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.last_byte) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_s_tready = r_ready;

endmodule

// ===== src/brf_dp.sv =====
module brf_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_wdata,
    input  logic [brf_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic [brf_pkg::TYPE_W-1:0]     i_s_tuser,
    input  logic                           i_m_tready,
    output logic                           o_m_tvalid,
    output logic [brf_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output logic                           o_m_tlast,
    output logic [brf_pkg::ST_W-1:0]       o_m_tuser,
    input  brf_pkg::t_cmd                  i_cmd,
    output brf_pkg::t_sts                  o_sts
);
    import brf_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN_L = LEN_W'(MAX_LEN);
    localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);

    function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    logic              r_mode;
    t_req              r_type;
    logic [LEN_W-1:0]  r_len;
    logic [DATA_W-1:0] r_data;

    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr, r_len_wr_ptr, r_len_rd_ptr;
    logic [PTR_W-1:0]  n_rd_ptr, n_len_rd_ptr;
    logic [CNT_W-1:0]  r_fill, r_rec_cnt;
    logic [LEN_W-1:0]  r_put_rem, r_remain, r_xfer;

    logic [DATA_W-1:0] byte_mem [DEPTH];
    logic [LEN_W-1:0]  len_mem  [DEPTH];
    logic [DATA_W-1:0] r_mem_q;
    logic [LEN_W-1:0]  r_lq_q;

    logic              r_out_valid, r_out_last;
    logic [DATA_W-1:0] r_out_data;
    logic [LEN_W-1:0]  r_out_xfer;
    t_status           r_out_status;

    // request evaluation
    t_status           ev_status;
    logic [LEN_W-1:0]  ev_xfer, get_n;
    logic              do_put_start, do_lq_push, do_byte_wr, do_clear, do_get, do_pop;
    logic              ev_stream;
    logic [CMP_W-1:0]  len_c, fill_c, free_c, lq_c;

    always_comb begin
        ev_status    = ST_OK;
        ev_xfer      = '0;
        get_n        = '0;
        do_put_start = 1'b0;
        do_lq_push   = 1'b0;
        do_byte_wr   = 1'b0;
        do_clear     = 1'b0;
        do_get       = 1'b0;
        do_pop       = 1'b0;
        len_c        = CMP_W'(r_len);
        fill_c       = CMP_W'(r_fill);
        free_c       = CMP_W'(DEPTH_C - r_fill);
        lq_c         = CMP_W'(r_lq_q);
        case (r_type)
            REQ_PUT_START: begin
                if (r_put_rem != '0 || r_len > MAX_LEN_L) begin
                    ev_status = ST_SEQUENCE;
                end else if (free_c < len_c) begin
                    ev_status = ST_NO_SPACE;
                end else if (r_mode && r_rec_cnt == DEPTH_C) begin
                    ev_status = ST_NO_SPACE;
                end else begin
                    do_put_start = 1'b1;
                    do_lq_push   = r_mode;
                end
            end
            REQ_PUT_BYTE: begin
                if (r_put_rem == '0 || r_fill == DEPTH_C) begin
                    ev_status = ST_SEQUENCE;
                end else begin
                    do_byte_wr = 1'b1;
                end
            end
            REQ_CLEAR: begin
                do_clear = 1'b1;
            end
            REQ_GET: begin
                if (r_mode) begin
                    if (r_rec_cnt == '0) begin
                        ev_status = ST_NO_DATA;
                    end else begin
                        ev_xfer = r_lq_q;
                        if (r_len < r_lq_q) begin
                            ev_status = ST_CAPACITY;
                        end else if (fill_c < lq_c) begin
                            ev_status = ST_NO_DATA;
                        end else begin
                            do_get = 1'b1;
                            do_pop = 1'b1;
                            get_n  = r_lq_q;
                        end
                    end
                end else begin
                    ev_xfer = r_len;
                    if (r_len > MAX_LEN_L) begin
                        ev_status = ST_SEQUENCE;
                    end else if (fill_c < len_c) begin
                        ev_status = ST_NO_DATA;
                    end else begin
                        do_get = 1'b1;
                        get_n  = r_len;
                    end
                end
            end
            default: ;
        endcase
        ev_stream = do_get && (get_n != '0);
        // an empty get reports a zero length
        if (do_get && get_n == '0) begin
            ev_xfer = '0;
        end
    end

    // next read addresses feed the registered memory reads
    always_comb begin
        n_rd_ptr     = r_rd_ptr;
        n_len_rd_ptr = r_len_rd_ptr;
        if (i_cmd.exec && do_clear) begin
            n_rd_ptr     = '0;
            n_len_rd_ptr = '0;
        end else begin
            if (i_cmd.exec && do_pop) begin
                n_len_rd_ptr = wrap_next(r_len_rd_ptr);
            end
            if (i_cmd.step) begin
                n_rd_ptr = wrap_next(r_rd_ptr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && do_byte_wr) begin
            byte_mem[r_wr_ptr] <= r_data;
        end
        r_mem_q <= byte_mem[n_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && do_lq_push) begin
            len_mem[r_len_wr_ptr] <= r_len;
        end
        r_lq_q <= len_mem[n_len_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_type <= t_req'(i_s_tuser);
            r_len  <= i_s_tdata[LEN_W-1:0];
            r_data <= i_s_tdata[LEN_W +: DATA_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 1'b0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_len_wr_ptr <= '0;
            r_len_rd_ptr <= '0;
            r_fill       <= '0;
            r_rec_cnt    <= '0;
            r_put_rem    <= '0;
            r_remain     <= '0;
            r_xfer       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            r_rd_ptr     <= n_rd_ptr;
            r_len_rd_ptr <= n_len_rd_ptr;
            if (i_cmd.exec) begin
                if (do_clear) begin
                    r_wr_ptr     <= '0;
                    r_len_wr_ptr <= '0;
                    r_fill       <= '0;
                    r_rec_cnt    <= '0;
                    r_put_rem    <= '0;
                end
                if (do_put_start) begin
                    r_put_rem <= r_len;
                end
                if (do_lq_push) begin
                    r_len_wr_ptr <= wrap_next(r_len_wr_ptr);
                    r_rec_cnt    <= r_rec_cnt + 1'b1;
                end
                if (do_byte_wr) begin
                    r_wr_ptr  <= wrap_next(r_wr_ptr);
                    r_fill    <= r_fill + 1'b1;
                    r_put_rem <= r_put_rem - 1'b1;
                end
                if (do_get) begin
                    r_fill   <= CNT_W'(fill_c - CMP_W'(get_n));
                    r_remain <= get_n;
                    r_xfer   <= get_n;
                end
                if (do_pop) begin
                    r_rec_cnt <= r_rec_cnt - 1'b1;
                end
            end
            if (i_cmd.step) begin
                r_remain <= r_remain - 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.exec && !ev_stream) || i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && !ev_stream) begin
            r_out_data   <= '0;
            r_out_last   <= 1'b1;
            r_out_status <= ev_status;
            r_out_xfer   <= ev_xfer;
        end else if (i_cmd.step) begin
            r_out_data   <= r_mem_q;
            r_out_last   <= (r_remain == LEN_W'(1));
            r_out_status <= ST_OK;
            r_out_xfer   <= r_xfer;
        end
    end

    assign o_sts.out_free     = !r_out_valid || i_m_tready;
    assign o_sts.start_stream = ev_stream;
    assign o_sts.last_byte    = (r_remain == LEN_W'(1));

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W - LEN_W - DATA_W){1'b0}}, r_out_xfer, r_out_data};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_status;

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= DEPTH_C)
        else $error("fill count above depth");

    a_rec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rec_cnt <= DEPTH_C)
        else $error("record count above depth");

    a_step_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> r_remain != '0)
        else $error("byte read with nothing left to stream");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec || i_cmd.step) |-> (!r_out_valid || i_m_tready))
        else $error("result loaded over a pending transaction");

    a_fill_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && do_byte_wr) |=> r_fill == $past(r_fill) + 1'b1)
        else $error("put byte did not advance fill count");
`endif

endmodule

// ===== src/byte_ring_fifo_with_record_lengths_unit.sv =====
// channel   dir  handshake             payload
// s_axis    in   tvalid / tready       tuser: req_type; tdata: req_len, wr_data
// m_axis    out  tvalid / tready       tuser: status; tdata: rd_data, xfer_len; tlast
// cfg       in   i_cfg_we (no wait)    i_cfg_wdata: record_mode
//
// put start, put byte, clear, empty and rejected gets: registered, then evaluated into
// the output register; next item taken once the request is evaluated
// served get of n bytes: one byte a cycle from the byte store read port unless stalled
// synchronous active-low reset clears pointers and counts; the stores are not cleared
// a stalled result holds in the output register; evaluation and streaming wait on it
module byte_ring_fifo_with_record_lengths_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [6:0] req_len, [14:7] wr_data, [15] zero
    input  logic [brf_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [brf_pkg::TYPE_W-1:0]    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] rd_data, [14:8] xfer_len, [15] zero
    output logic [brf_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast,
    // [2:0] status
    output logic [brf_pkg::ST_W-1:0]      m_axis_tuser
);
    import brf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    brf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    brf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tlast   (m_axis_tlast),
        .o_m_tuser   (m_axis_tuser),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
